@@ rtl/core/sbp_pkg.sv @@
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types and constants of the spinning box projection unit.
// ----------------------------------------------------------------------------
package sbp_pkg;

  localparam int CoordW   = 16;
  localparam int ShiftW   = 5;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int CmdCount = 24;
  localparam int CmdW     = 5;

  // register map of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EYE_DISTANCE    = 3'd0,
    CFG_DEPTH_NUMERATOR = 3'd1,
    CFG_PROJ_SHIFT      = 3'd2,
    CFG_CENTER_X        = 3'd3,
    CFG_CENTER_Y        = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] EyeDistanceRst    = 16'd1600;
  localparam logic [23:0] DepthNumeratorRst = 24'd204800;
  localparam logic [3:0]  ProjShiftRst      = 4'd10;
  localparam logic [11:0] CenterXRst        = 12'd512;
  localparam logic [11:0] CenterYRst        = 12'd400;
  localparam logic [63:0] RotStartInt       = 64'd200;

  // edge groups of the command sequence
  localparam logic [1:0] GrpVertical = 2'd0;
  localparam logic [1:0] GrpTop      = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/core/sbp_stream_if.sv @@
// ----------------------------------------------------------------------------
// sbp stream interfaces
// Valid/ready channels for the tick input and the line command output.
// ----------------------------------------------------------------------------
interface sbp_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] rotate_shift;

  modport source (output valid, output rotate_shift, input ready);
  modport sink   (input valid, input rotate_shift, output ready);
endinterface

interface sbp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic               draw_set;
  logic               last;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, output draw_set, output last, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, input draw_set, input last, output ready);
endinterface

@@ rtl/core/spinning_box_projection_unit.sv @@
// ----------------------------------------------------------------------------
// spinning_box_projection_unit
// Rotating box projected in perspective, emitted as erase/draw line commands.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        handshake
//  in_if     in   rotate_shift                                   valid/ready
//  out_if    out  start_x start_y end_x end_y draw_set last      valid/ready
//  cfg       in   cfg_idx_i cfg_wdata_i                          cfg_we_i
//
//  the shared one-bit-per-cycle divider, NumW = max(47 - F, 24) bits wide with
//  F = FRACTION_BITS, runs up to eight times per tick, two divisions per corner;
//  a corner with a divisor that is not positive skips its two divisions.
//  the 24 commands leave through one output register, one per cycle when the
//  sink is ready; a stalled sink holds the sequencer in its emit phase.
//  in_if.ready is high only between ticks; reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module spinning_box_projection_unit
  import sbp_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  sbp_in_if.sink              in_if,
  sbp_out_if.source           out_if
);

  localparam int IntW = 33 - FRACTION_BITS;
  localparam int DivW = ((IntW > 17) ? IntW : 17) + 1;
  localparam int DenW = DivW - 1;
  localparam int NumW = ((IntW + 14) > 24) ? (IntW + 14) : 24;
  localparam logic [31:0] RotInit = 32'(RotStartInt << FRACTION_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WAIT_X,
    ST_WAIT_Y,
    ST_EMIT,
    ST_STEP_X,
    ST_STEP_Y
  } state_e;

  // configuration registers
  logic [15:0] eye_q;
  logic [23:0] depth_q;
  logic [3:0]  pshift_q;
  logic [11:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q    <= EyeDistanceRst;
      depth_q  <= DepthNumeratorRst;
      pshift_q <= ProjShiftRst;
      cx_q     <= CenterXRst;
      cy_q     <= CenterYRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EYE_DISTANCE:    eye_q    <= cfg_wdata_i[15:0];
        CFG_DEPTH_NUMERATOR: depth_q  <= cfg_wdata_i;
        CFG_PROJ_SHIFT:      pshift_q <= cfg_wdata_i[3:0];
        CFG_CENTER_X:        cx_q     <= cfg_wdata_i[11:0];
        CFG_CENTER_Y:        cy_q     <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  state_e                   state_q;
  logic [31:0]              rot_x_q, rot_y_q;
  logic [ShiftW-1:0]        s_q;
  logic signed [IntW-1:0]   a_q, b_q;
  logic [1:0]               c_q;
  logic                     uneg_q;
  logic [CmdW-1:0]          k_q;
  logic [CoordW-1:0]        prev_x_q [4];
  logic [CoordW-1:0]        prev_y_q [4];
  logic [CoordW-1:0]        new_x_q  [4];
  logic [CoordW-1:0]        new_y_q  [4];
  logic                     ov_q, oset_q, olast_q;
  logic [CoordW-1:0]        osx_q, osy_q, oex_q, oey_q;

  // corner selection and divisor
  logic signed [IntW-1:0] u_sel, v_sel, u_abs;
  logic signed [DivW-1:0] denom_s;
  logic                   div_pos;
  logic [NumW-1:0]        num_x, num_y;

  always_comb begin
    case (c_q)
      2'd0:    begin u_sel = a_q;  v_sel = b_q;  end
      2'd1:    begin u_sel = b_q;  v_sel = -a_q; end
      2'd2:    begin u_sel = -a_q; v_sel = -b_q; end
      default: begin u_sel = -b_q; v_sel = a_q;  end
    endcase
  end

  assign denom_s = $signed(DivW'(eye_q)) + DivW'(v_sel);
  assign div_pos = !denom_s[DivW-1] && (denom_s != '0);
  assign u_abs   = u_sel[IntW-1] ? -u_sel : u_sel;
  assign num_x   = NumW'(u_abs[IntW-2:0]) << pshift_q;
  assign num_y   = NumW'(depth_q);

  // shared divider
  logic              div_start;
  logic [NumW-1:0]   div_numer;
  logic [CoordW-1:0] div_quot;
  div_status_t       div_stat;

  assign div_start = ((state_q == ST_SETUP) && div_pos) ||
                     ((state_q == ST_WAIT_X) && div_stat.done);
  assign div_numer = (state_q == ST_SETUP) ? num_x : num_y;

  sbp_divider #(
    .NUM_W (NumW),
    .DEN_W (DenW)
  ) u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .numer_i  (div_numer),
    .denom_i  (denom_s[DenW-1:0]),
    .quot_o   (div_quot),
    .status_o (div_stat)
  );

  // line command for index k; corners rotate so corner i sits at 0, i+1 at 1
  logic [1:0]        grp;
  logic [CoordW-1:0] x0, y0, x1, y1, sx, sy, ex, ey;

  assign grp = k_q[4:3];

  always_comb begin
    x0 = k_q[0] ? new_x_q[0] : prev_x_q[0];
    y0 = k_q[0] ? new_y_q[0] : prev_y_q[0];
    x1 = k_q[0] ? new_x_q[1] : prev_x_q[1];
    y1 = k_q[0] ? new_y_q[1] : prev_y_q[1];
    sx = x0;
    sy = (grp == GrpVertical || grp == GrpTop) ? y0 : -y0;
    case (grp)
      GrpVertical: begin ex = x0; ey = -y0; end
      GrpTop:      begin ex = x1; ey = y1;  end
      default:     begin ex = x1; ey = -y1; end
    endcase
  end

  logic [31:0] step_y, step_x;
  assign step_y = 32'($signed(rot_y_q) >>> s_q);
  assign step_x = 32'($signed(rot_x_q) >>> s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rot_x_q <= -RotInit;
      rot_y_q <= RotInit;
      s_q     <= '0;
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      uneg_q  <= 1'b0;
      k_q     <= '0;
      ov_q    <= 1'b0;
      oset_q  <= 1'b0;
      olast_q <= 1'b0;
      osx_q   <= '0;
      osy_q   <= '0;
      oex_q   <= '0;
      oey_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        prev_x_q[i] <= '0;
        prev_y_q[i] <= '0;
        new_x_q[i]  <= '0;
        new_y_q[i]  <= '0;
      end
    end else begin
      // in the emit phase a free output register is always refilled
      if (out_if.ready && state_q != ST_EMIT) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            s_q     <= in_if.rotate_shift;
            a_q     <= IntW'($signed(rot_x_q) >>> FRACTION_BITS);
            b_q     <= IntW'($signed(rot_y_q) >>> FRACTION_BITS);
            c_q     <= '0;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          uneg_q <= u_sel[IntW-1];
          if (div_pos) begin
            state_q <= ST_WAIT_X;
          end else begin
            // divisor not positive: both coordinates are zero
            new_x_q[c_q] <= '0;
            new_y_q[c_q] <= '0;
            c_q          <= c_q + 2'd1;
            if (c_q == 2'd3) begin
              k_q     <= '0;
              state_q <= ST_EMIT;
            end
          end
        end
        ST_WAIT_X: begin
          if (div_stat.done) begin
            new_x_q[c_q] <= uneg_q ? -div_quot : div_quot;
            state_q      <= ST_WAIT_Y;
          end
        end
        ST_WAIT_Y: begin
          if (div_stat.done) begin
            new_y_q[c_q] <= div_quot;
            c_q          <= c_q + 2'd1;
            if (c_q == 2'd3) begin
              k_q     <= '0;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_SETUP;
            end
          end
        end
        ST_EMIT: begin
          if (!ov_q || out_if.ready) begin
            ov_q    <= 1'b1;
            osx_q   <= CoordW'(cx_q) + sx;
            osy_q   <= CoordW'(cy_q) + sy;
            oex_q   <= CoordW'(cx_q) + ex;
            oey_q   <= CoordW'(cy_q) + ey;
            oset_q  <= k_q[0];
            olast_q <= (k_q == CmdW'(CmdCount - 1));
            k_q     <= k_q + CmdW'(1);
            if (k_q[0]) begin
              for (int i = 0; i < 4; i++) begin
                prev_x_q[i] <= prev_x_q[(i + 1) % 4];
                prev_y_q[i] <= prev_y_q[(i + 1) % 4];
                new_x_q[i]  <= new_x_q[(i + 1) % 4];
                new_y_q[i]  <= new_y_q[(i + 1) % 4];
              end
            end
            if (k_q == CmdW'(CmdCount - 1)) begin
              state_q <= ST_STEP_X;
            end
          end
        end
        ST_STEP_X: begin
          for (int i = 0; i < 4; i++) begin
            prev_x_q[i] <= new_x_q[i];
            prev_y_q[i] <= new_y_q[i];
          end
          rot_x_q <= rot_x_q - step_y;
          state_q <= ST_STEP_Y;
        end
        ST_STEP_Y: begin
          rot_y_q <= rot_y_q + step_x;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_if.ready     = (state_q == ST_IDLE);
  assign out_if.valid    = ov_q;
  assign out_if.start_x  = $signed(osx_q);
  assign out_if.start_y  = $signed(osy_q);
  assign out_if.end_x    = $signed(oex_q);
  assign out_if.end_y    = $signed(oey_q);
  assign out_if.draw_set = oset_q;
  assign out_if.last     = olast_q;

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> state_q == ST_SETUP)
    else $error("accepted tick did not start projection");

  a_start_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_WAIT_X || state_q == ST_WAIT_Y)
    else $error("divider result with no one waiting");

  a_idle_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !div_stat.busy)
    else $error("ready while a division runs");

  a_last_ends_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && (!ov_q || out_if.ready) && k_q == CmdW'(CmdCount - 1)
    |=> ov_q && olast_q && state_q == ST_STEP_X)
    else $error("last command not flagged");

endmodule

@@ rtl/core/sbp_divider.sv @@
// ----------------------------------------------------------------------------
// sbp_divider
// Restoring unsigned divider, one quotient bit per cycle, low 16 bits kept.
// ----------------------------------------------------------------------------
module sbp_divider
  import sbp_pkg::*;
#(
  parameter int NUM_W = 31,
  parameter int DEN_W = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  numer_i,
  input  logic [DEN_W-1:0]  denom_i,
  output logic [CoordW-1:0] quot_o,
  output div_status_t       status_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [CoordW-1:0] quo_q;
  logic [DEN_W:0]    trial, diff;
  logic              qbit;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_q <= num_q << 1;
      quo_q <= {quo_q[CoordW-2:0], qbit};
    end else if (start_i) begin
      rem_q <= '0;
      num_q <= numer_i;
      den_q <= denom_i;
    end
  end

  assign quot_o   = quo_q;
  assign status_o = '{busy: busy_q, done: done_q};

  a_start_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_q |=> busy_q)
    else $error("divider did not start");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a run");

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < den_q)
    else $error("divider remainder out of range");

endmodule

@@ sim/sbp_line_checker.sv @@
// ----------------------------------------------------------------------------
// sbp_line_checker
// Watches the tick and line command channels of the spinning box projection
// unit. It keeps its own copy of the rotating point, the last frame's corners
// and the register file, predicts the 24 line commands of every accepted tick
// and compares each accepted command with the oldest prediction.
// ----------------------------------------------------------------------------
module sbp_line_checker
  import sbp_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  sbp_in_if                   in_mon,
  sbp_out_if                  out_mon,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic              draw_set;
    logic              last;
  } line_cmd_t;

  // register file copy
  logic [15:0] eye_dist;
  logic [23:0] depth_num;
  logic [3:0]  proj_shift;
  logic [11:0] ctr_x;
  logic [11:0] ctr_y;

  // rotating point and the corners drawn by the previous tick
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic [CoordW-1:0]  prev_px [4];
  logic [CoordW-1:0]  prev_py [4];

  line_cmd_t expected_lines [$];
  line_cmd_t want;
  int        mismatches = 0;
  int        lines_seen;

  assign mismatches_o = mismatches;
  assign pending_o    = expected_lines.size();

  task automatic queue_line(input logic [CoordW-1:0] x1, input logic [CoordW-1:0] y1,
                            input logic [CoordW-1:0] x2, input logic [CoordW-1:0] y2,
                            input logic draw, inout int k);
    line_cmd_t c;
    c.start_x  = x1 + {4'b0, ctr_x};
    c.start_y  = y1 + {4'b0, ctr_y};
    c.end_x    = x2 + {4'b0, ctr_x};
    c.end_y    = y2 + {4'b0, ctr_y};
    c.draw_set = draw;
    c.last     = (k == CmdCount - 1);
    expected_lines.push_back(c);
    k++;
  endtask

  task automatic project_tick(input logic [ShiftW-1:0] rot_shift);
    longint            a, b, div, qx, qy;
    longint            cu [4];
    longint            cv [4];
    logic [CoordW-1:0] nx [4];
    logic [CoordW-1:0] ny [4];
    int                j;
    int                k;
    k = 0;
    a = rot_x >>> FRACTION_BITS;
    b = rot_y >>> FRACTION_BITS;
    cu = '{a, b, -a, -b};
    cv = '{b, -a, -b, a};
    for (int i = 0; i < 4; i++) begin
      div = longint'(eye_dist) + cv[i];
      // corner at or behind the eye collapses to the origin
      if (div > 0) begin
        qx = (cu[i] <<< proj_shift) / div;
        qy = longint'(depth_num) / div;
      end else begin
        qx = 0;
        qy = 0;
      end
      nx[i] = qx[CoordW-1:0];
      ny[i] = qy[CoordW-1:0];
    end
    for (int i = 0; i < 4; i++) begin
      queue_line(prev_px[i], prev_py[i], prev_px[i], -prev_py[i], 1'b0, k);
      queue_line(nx[i], ny[i], nx[i], -ny[i], 1'b1, k);
    end
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      queue_line(prev_px[i], prev_py[i], prev_px[j], prev_py[j], 1'b0, k);
      queue_line(nx[i], ny[i], nx[j], ny[j], 1'b1, k);
    end
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      queue_line(prev_px[i], -prev_py[i], prev_px[j], -prev_py[j], 1'b0, k);
      queue_line(nx[i], -ny[i], nx[j], -ny[j], 1'b1, k);
    end
    prev_px = nx;
    prev_py = ny;
    // minsky step, y uses the freshly updated x
    rot_x = rot_x - (rot_y >>> rot_shift);
    rot_y = rot_y + (rot_x >>> rot_shift);
  endtask

  task automatic compare_field(input string fname, input logic [CoordW-1:0] exp_v,
                               input logic [CoordW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: line %0d %s mismatch: expected %0d, actual %0d",
               $time, lines_seen, fname, $signed(exp_v), $signed(act_v));
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_dist   = EyeDistanceRst;
      depth_num  = DepthNumeratorRst;
      proj_shift = ProjShiftRst;
      ctr_x      = CenterXRst;
      ctr_y      = CenterYRst;
      rot_y      = 32'(RotStartInt << FRACTION_BITS);
      rot_x      = -rot_y;
      for (int i = 0; i < 4; i++) begin
        prev_px[i] = '0;
        prev_py[i] = '0;
      end
      expected_lines.delete();
      lines_seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EYE_DISTANCE:    eye_dist   = cfg_wdata_i[15:0];
          CFG_DEPTH_NUMERATOR: depth_num  = cfg_wdata_i[23:0];
          CFG_PROJ_SHIFT:      proj_shift = cfg_wdata_i[3:0];
          CFG_CENTER_X:        ctr_x      = cfg_wdata_i[11:0];
          CFG_CENTER_Y:        ctr_y      = cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      // a command of a new tick cannot leave at the edge that accepts it
      if (out_mon.valid && out_mon.ready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: line %0d arrived with nothing expected: %0d %0d %0d %0d %0b %0b",
                   $time, lines_seen, out_mon.start_x, out_mon.start_y, out_mon.end_x,
                   out_mon.end_y, out_mon.draw_set, out_mon.last);
          mismatches++;
        end else begin
          want = expected_lines.pop_front();
          compare_field("start_x", want.start_x, out_mon.start_x);
          compare_field("start_y", want.start_y, out_mon.start_y);
          compare_field("end_x", want.end_x, out_mon.end_x);
          compare_field("end_y", want.end_y, out_mon.end_y);
          compare_field("draw_set", {15'b0, want.draw_set}, {15'b0, out_mon.draw_set});
          compare_field("last", {15'b0, want.last}, {15'b0, out_mon.last});
        end
        lines_seen++;
      end
      if (in_mon.valid && in_mon.ready) begin
        project_tick(in_mon.rotate_shift);
      end
    end
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Regression bench of the spinning box projection unit. A directed opening
// covers the register extremes, collapsed and wide projections, coordinate
// wrap and ignored register writes; then four random phases each take a new
// register setting under different sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
  import sbp_pkg::*;

  localparam int ItemsPerPhase = 33;
  localparam int CfgSettle     = 16;
  localparam int EndSettle     = 300;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  idle_pct;
  int                  stall_pct;
  int                  mismatches;
  int                  pending;

  sbp_in_if  tick_ch ();
  sbp_out_if line_ch ();

  spinning_box_projection_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (tick_ch),
    .out_if     (line_ch)
  );

  sbp_line_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_mon      (tick_ch),
    .out_mon     (line_ch),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("spinning_box_projection_unit regression: fail");
    $finish;
  end

  // receiver back-pressure
  initial begin
    line_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      line_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send(input logic [ShiftW-1:0] sh);
    while ($urandom_range(99) < idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.rotate_shift <= sh;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  task automatic drain(input int settle);
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // junk above the register width must be dropped by the block
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value,
                           input int bits);
    logic [CfgDataW-1:0] mask;
    mask      = ~({CfgDataW{1'b1}} << bits);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= (CfgDataW'($urandom()) & ~mask) | (value & mask);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input logic [15:0] eye, input logic [23:0] depth,
                       input logic [3:0] psh, input logic [11:0] cx, input logic [11:0] cy);
    drain(CfgSettle);
    cfg_write(CFG_EYE_DISTANCE, 24'(eye), 16);
    cfg_write(CFG_DEPTH_NUMERATOR, depth, 24);
    cfg_write(CFG_PROJ_SHIFT, 24'(psh), 4);
    cfg_write(CFG_CENTER_X, 24'(cx), 12);
    cfg_write(CFG_CENTER_Y, 24'(cy), 12);
  endtask

  initial begin
    logic [15:0] r_eye;
    logic [23:0] r_depth;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_wdata            <= '0;
    tick_ch.valid        <= 1'b0;
    tick_ch.rotate_shift <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, slowest and fastest rotation
    send(5'd31);
    send(5'd0);
    send(5'd0);
    send(5'd1);
    // eye right at the box: corners behind it collapse, the rest overflow
    setup(16'd1, 24'hFFFFFF, 4'd15, 12'd4095, 12'd4095);
    send(5'd31);
    send(5'd5);
    send(5'd0);
    // far eye, zero numerator and offsets; a spare index must change nothing
    setup(16'hFFFF, 24'd0, 4'd0, 12'd0, 12'd0);
    cfg_write(CfgIdxSpare, 24'hFFFFFF, 24);
    send(5'd16);
    send(5'd31);
    // divisor near one on some corners
    setup(16'd201, 24'd4096, 4'd8, 12'd2048, 12'd100);
    send(5'd2);
    send(5'd3);
    send(5'd0);
    send(5'd7);

    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(3))
        0:       r_eye = 16'd1;
        1:       r_eye = 16'hFFFF;
        2:       r_eye = 16'($urandom_range(1, 450));
        default: r_eye = 16'($urandom_range(450, 3000));
      endcase
      case ($urandom_range(2))
        0:       r_depth = 24'd0;
        1:       r_depth = 24'hFFFFFF;
        default: r_depth = 24'($urandom());
      endcase
      setup(r_eye, r_depth, 4'($urandom_range(15)), 12'($urandom_range(4095)),
            12'($urandom_range(4095)));
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send(($urandom_range(3) == 0) ? 5'($urandom_range(4)) : 5'($urandom_range(31)));
      end
    end

    drain(EndSettle);
    if (mismatches == 0 && pending == 0) begin
      $display("spinning_box_projection_unit regression: pass");
    end else begin
      $display("spinning_box_projection_unit regression: fail");
    end
    $finish;
  end

endmodule
